// ----- sv/scpfc_pkg.sv -----
// ----------------------------------------------------------------------------
// scpfc_pkg
// Shared types, constants and tables of the sliding-contact PI force
// controller: configuration record, queued item layout, CORDIC arctangents.
// ----------------------------------------------------------------------------
package scpfc_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS      = 16;
    localparam int TIME_FRAC_BITS = 20;
    localparam int WQ             = 30;
    localparam int CORDIC_STEPS   = 30;
    localparam int SQRT_STEPS     = 31;

    // pi/2 and the 0.04 m lever arm, Q30
    localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [32:0] LEVER_Q30   = 33'sd42949673;

    // Configuration register indexes
    localparam logic [2:0] REG_TARGET_ANGLE = 3'd0;
    localparam logic [2:0] REG_TARGET_SPEED = 3'd1;
    localparam logic [2:0] REG_TARGET_FORCE = 3'd2;
    localparam logic [2:0] REG_FORCE_P_GAIN = 3'd3;
    localparam logic [2:0] REG_FORCE_I_GAIN = 3'd4;
    localparam logic [2:0] REG_ANGLE_GAIN   = 3'd5;

    // Configuration record handed to the datapath
    typedef struct packed {
        logic [17:0]        target_angle;
        logic signed [31:0] target_speed;
        logic signed [31:0] target_force;
        logic signed [31:0] force_p_gain;
        logic signed [31:0] force_i_gain;
        logic signed [31:0] angle_gain;
    } cfg_t;

    // Classified item: clamped axis, elapsed ticks, saturated force error
    typedef struct packed {
        logic signed [17:0] c;
        logic signed [47:0] dt;
        logic signed [31:0] fe;
    } item_t;

    // Truncated Q30 arctangent of 2^-i
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] r;
        begin
            case (i)
                5'd0:    r = 30'h3243F6A8;
                5'd1:    r = 30'h1DAC6705;
                5'd2:    r = 30'h0FADBAFC;
                5'd3:    r = 30'h07F56EA6;
                5'd4:    r = 30'h03FEAB76;
                5'd5:    r = 30'h01FFD55B;
                5'd6:    r = 30'h00FFFAAA;
                5'd7:    r = 30'h007FFF55;
                5'd8:    r = 30'h003FFFEA;
                5'd9:    r = 30'h001FFFFD;
                5'd10:   r = 30'h000FFFFF;
                5'd11:   r = 30'h0007FFFF;
                5'd12:   r = 30'h0003FFFF;
                5'd13:   r = 30'h0001FFFF;
                5'd14:   r = 30'h0000FFFF;
                5'd15:   r = 30'h00007FFF;
                5'd16:   r = 30'h00003FFF;
                5'd17:   r = 30'h00001FFF;
                5'd18:   r = 30'h00000FFF;
                5'd19:   r = 30'h000007FF;
                5'd20:   r = 30'h000003FF;
                5'd21:   r = 30'h000001FF;
                5'd22:   r = 30'h000000FF;
                5'd23:   r = 30'h0000007F;
                5'd24:   r = 30'h0000003F;
                5'd25:   r = 30'h0000001F;
                5'd26:   r = 30'h0000000F;
                5'd27:   r = 30'h00000008;
                5'd28:   r = 30'h00000004;
                5'd29:   r = 30'h00000002;
                default: r = 30'h00000000;
            endcase
            return r;
        end
    endfunction

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'sh0_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (v < -66'sh0_8000_0000)
                r = -32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// ----- sv/scpfc_queue.sv -----
// ----------------------------------------------------------------------------
// scpfc_queue
// Two-entry item queue between the front end and the datapath.
// ----------------------------------------------------------------------------
module scpfc_queue
    import scpfc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head_item
);

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_item = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- sv/scpfc_front.sv -----
// ----------------------------------------------------------------------------
// scpfc_front
// Takes samples, clamps the axis, works out elapsed time and force error,
// and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module scpfc_front
    import scpfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [47:0]        sim_time,
    input  logic signed [17:0] axis_x,
    input  logic signed [31:0] normal_force,
    input  logic signed [31:0] target_force,
    input  logic               q_full,
    output logic               push,
    output item_t              push_item
);

    logic [47:0]        last_time_reg;
    logic               time_seen_reg;
    logic signed [33:0] fe_wide;
    logic [47:0]        dt_raw;
    logic signed [17:0] c_clamp;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Axis clamp to [-1, 1]
    always_comb
    begin
        if (axis_x > 18'sd65536)
            c_clamp = 18'sd65536;
        else if (axis_x < -18'sd65536)
            c_clamp = -18'sd65536;
        else
            c_clamp = axis_x;
    end

    // Elapsed ticks, zero on the first sample, wraps modulo 2^48
    assign dt_raw = time_seen_reg ? (sim_time - last_time_reg) : 48'd0;

    // Force error against the negated target
    assign fe_wide = -34'(target_force) - 34'(normal_force);

    assign push_item = '{c: c_clamp, dt: $signed(dt_raw), fe: sat32(66'(fe_wide))};

    // Time stamp history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= 48'd0;
            time_seen_reg <= 1'b0;
        end
        else if (push)
        begin
            last_time_reg <= sim_time;
            time_seen_reg <= 1'b1;
        end
    end

endmodule

// ----- sv/scpfc_back.sv -----
// ----------------------------------------------------------------------------
// scpfc_back
// Sequenced datapath: bit-serial square root, CORDIC contact angle, PI
// integral and output products on one shared multiplier, output register.
// ----------------------------------------------------------------------------
module scpfc_back
    import scpfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_not_empty,
    input  item_t              q_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] lin_vel_x,
    output logic signed [31:0] lin_vel_z,
    output logic signed [31:0] rot_vel_y
);

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_CSQ   = 16'h0002,
        ST_SQI   = 16'h0004,
        ST_SQRT  = 16'h0008,
        ST_CINIT = 16'h0010,
        ST_CORD  = 16'h0020,
        ST_MW    = 16'h0040,
        ST_MHI   = 16'h0080,
        ST_MLO   = 16'h0100,
        ST_INT   = 16'h0200,
        ST_MPI   = 16'h0400,
        ST_MM    = 16'h0800,
        ST_MX    = 16'h1000,
        ST_MS    = 16'h2000,
        ST_MC    = 16'h4000,
        ST_OUT   = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0]         cnt_reg;
    logic               out_valid_reg;
    logic signed [31:0] integral_reg, integral_next;

    // Item and intermediate values
    logic signed [17:0] c_reg;
    logic signed [47:0] dt_reg;
    logic signed [31:0] fe_reg;
    logic [61:0]        vsh_reg;
    logic [34:0]        rem_reg;
    logic [31:0]        root_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic signed [31:0] w_reg;
    logic [54:0]        hi_reg;
    logic signed [49:0] pterm_reg;
    logic signed [31:0] pi_reg;
    logic signed [31:0] m_reg;
    logic signed [31:0] lx_reg;
    logic signed [65:0] prod_reg;

    // Shared multiplier
    logic               mul_en;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    logic signed [65:0] prod_r16, prod_r30;
    logic [34:0]        rem_sh, trial;
    logic signed [33:0] c30, s34, dx, dy;
    logic signed [19:0] ang;
    logic signed [20:0] ang_err;
    logic [31:0]        abs_e;
    logic [47:0]        abs_d;
    logic               step_neg;
    logic [63:0]        step_sum;
    logic [33:0]        step_q;
    logic signed [65:0] step_s;
    logic               load_out;

    assign pop       = (state_reg == ST_IDLE) && q_not_empty;
    assign out_valid = out_valid_reg;
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // Rounded scalings of the last product
    assign prod_r16 = (prod_reg + 66'sd32768) >>> FRAC_BITS;
    assign prod_r30 = (prod_reg + 66'sd536870912) >>> WQ;

    // Square root step
    assign rem_sh = {rem_reg[32:0], vsh_reg[61:60]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // CORDIC start vector and step shifts
    assign c30 = 34'(c_reg) <<< (WQ - FRAC_BITS);
    assign s34 = $signed({2'b00, root_reg});
    assign dx  = y_reg >>> cnt_reg;
    assign dy  = x_reg >>> cnt_reg;

    // Angle rounded to FRAC_BITS and its error
    assign ang     = 20'((z_reg + 33'sd8192) >>> (WQ - FRAC_BITS));
    assign ang_err = 21'(ang) - $signed({3'b000, cfg.target_angle});

    // Integral step magnitude, capped at 2^33
    assign abs_e    = fe_reg[31] ? 32'(-33'(fe_reg)) : 32'(fe_reg);
    assign abs_d    = dt_reg[47] ? 48'(-dt_reg) : 48'(dt_reg);
    assign step_neg = fe_reg[31] != dt_reg[47];
    assign step_sum = {hi_reg[38:0], 24'd0} + {8'd0, prod_reg[55:0]}
                      + 64'd524288;
    always_comb
    begin
        if (hi_reg >= 55'd549755813888)
            step_q = 34'h2_0000_0000;
        else if ((step_sum >> TIME_FRAC_BITS) > 64'h2_0000_0000)
            step_q = 34'h2_0000_0000;
        else
            step_q = step_sum[53:20];
    end
    assign step_s        = $signed({32'd0, step_q});
    assign integral_next = step_neg ? sat32(66'(integral_reg) - step_s)
                                    : sat32(66'(integral_reg) + step_s);

    // Multiplier operand selection
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_CSQ:
            begin
                mul_a = 33'(c_reg);
                mul_b = 33'(c_reg);
            end
            ST_MW:
            begin
                mul_a = 33'(cfg.angle_gain);
                mul_b = 33'(ang_err);
            end
            ST_MHI:
            begin
                mul_a = $signed({1'b0, abs_e});
                mul_b = $signed({9'd0, abs_d[47:24]});
            end
            ST_MLO:
            begin
                mul_a = $signed({1'b0, abs_e});
                mul_b = $signed({9'd0, abs_d[23:0]});
            end
            ST_INT:
            begin
                mul_a = 33'(cfg.force_p_gain);
                mul_b = 33'(fe_reg);
            end
            ST_MPI:
            begin
                mul_a = 33'(cfg.force_i_gain);
                mul_b = 33'(integral_reg);
            end
            ST_MM:
            begin
                mul_a = 33'(w_reg);
                mul_b = LEVER_Q30;
            end
            ST_MS:
            begin
                mul_a = 33'(m_reg);
                mul_b = $signed({1'b0, root_reg});
            end
            ST_MC:
            begin
                mul_a = 33'(m_reg);
                mul_b = 33'(c_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_not_empty) state_next = ST_CSQ;
            ST_CSQ:   state_next = ST_SQI;
            ST_SQI:   state_next = ST_SQRT;
            ST_SQRT:  if (cnt_reg == 5'(SQRT_STEPS - 1)) state_next = ST_CINIT;
            ST_CINIT: state_next = ST_CORD;
            ST_CORD:  if (cnt_reg == 5'(CORDIC_STEPS - 1)) state_next = ST_MW;
            ST_MW:    state_next = ST_MHI;
            ST_MHI:   state_next = ST_MLO;
            ST_MLO:   state_next = ST_INT;
            ST_INT:   state_next = ST_MPI;
            ST_MPI:   state_next = ST_MM;
            ST_MM:    state_next = ST_MX;
            ST_MX:    state_next = ST_MS;
            ST_MS:    state_next = ST_MC;
            ST_MC:    state_next = ST_OUT;
            ST_OUT:   if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
            integral_reg  <= 32'sd0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_SQRT && cnt_reg != 5'(SQRT_STEPS - 1))
                || (state_reg == ST_CORD && cnt_reg != 5'(CORDIC_STEPS - 1)))
                cnt_reg <= cnt_reg + 5'd1;
            else
                cnt_reg <= 5'd0;
            if (state_reg == ST_INT)
                integral_reg <= integral_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE:
            begin
                c_reg  <= q_item.c;
                dt_reg <= q_item.dt;
                fe_reg <= q_item.fe;
            end
            ST_SQI:
            begin
                vsh_reg  <= (62'd1 << 60) - 62'({prod_reg[32:0], 28'd0});
                rem_reg  <= 35'd0;
                root_reg <= 32'd0;
            end
            ST_SQRT:
            begin
                vsh_reg <= {vsh_reg[59:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            ST_CINIT:
            begin
                if (c_reg < 0)
                begin
                    x_reg <= s34;
                    y_reg <= -c30;
                    z_reg <= HALF_PI_Q30;
                end
                else
                begin
                    x_reg <= c30;
                    y_reg <= s34;
                    z_reg <= 33'sd0;
                end
            end
            ST_CORD:
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + $signed({3'b000, atan_q30(cnt_reg)});
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - $signed({3'b000, atan_q30(cnt_reg)});
                end
            end
            ST_MHI:  w_reg     <= sat32(prod_r16);
            ST_MLO:  hi_reg    <= prod_reg[54:0];
            ST_MPI:  pterm_reg <= prod_r16[49:0];
            ST_MM:   pi_reg    <= sat32(66'(pterm_reg) + prod_r16);
            ST_MX:   m_reg     <= prod_r30[31:0];
            ST_MC:   lx_reg    <= sat32(prod_r30 - 66'(cfg.target_speed));
            ST_OUT:
            begin
                if (load_out)
                begin
                    lin_vel_x <= lx_reg;
                    lin_vel_z <= sat32(66'(pi_reg) - prod_r16);
                    rot_vel_y <= w_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- sv/sliding_contact_pi_force_control_core.sv -----
// ----------------------------------------------------------------------------
// sliding_contact_pi_force_control_core
// PI normal-force and contact-angle controller for a tool sliding on a
// surface, Q16.16 in and out.
// ----------------------------------------------------------------------------
// A sample taken from the queue has its result in the output register after
// squaring the axis, setting up, a bit-serial square root for sin of the
// contact angle, loading the CORDIC, 30 CORDIC iterations, the rotation rate,
// PI integral and output products on the one shared 33x33 multiplier, and
// loading the result. The datapath works one item at a time. A two-item queue
// sits in front of the datapath, so samples are taken while earlier ones are
// still being worked; a result waiting on the consumer holds the datapath,
// and the input stalls once the queue is full as well. The integral and the
// time stamp history reset to zero; configuration writes are always ready
// and unknown indexes are ignored.
// ----------------------------------------------------------------------------
module sliding_contact_pi_force_control_core
    import scpfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [47:0]        sim_time,
    input  logic signed [17:0] axis_x,
    input  logic signed [31:0] normal_force,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] lin_vel_x,
    output logic signed [31:0] lin_vel_z,
    output logic signed [31:0] rot_vel_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cfg_t  cfg_reg;
    logic  push, pop, q_full, q_not_empty;
    item_t push_item, head_item;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_angle <= 18'd65536;
            cfg_reg.target_speed <= 32'sd328;
            cfg_reg.target_force <= 32'sd655360;
            cfg_reg.force_p_gain <= 32'sd6554;
            cfg_reg.force_i_gain <= 32'sd3277;
            cfg_reg.angle_gain   <= 32'sd3277;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TARGET_ANGLE: cfg_reg.target_angle <= cfg_data[17:0];
                REG_TARGET_SPEED: cfg_reg.target_speed <= $signed(cfg_data);
                REG_TARGET_FORCE: cfg_reg.target_force <= $signed(cfg_data);
                REG_FORCE_P_GAIN: cfg_reg.force_p_gain <= $signed(cfg_data);
                REG_FORCE_I_GAIN: cfg_reg.force_i_gain <= $signed(cfg_data);
                REG_ANGLE_GAIN:   cfg_reg.angle_gain   <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // Front end
    scpfc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sim_time     (sim_time),
        .axis_x       (axis_x),
        .normal_force (normal_force),
        .target_force (cfg_reg.target_force),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item)
    );

    // Item queue
    scpfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // Datapath
    scpfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .lin_vel_x   (lin_vel_x),
        .lin_vel_z   (lin_vel_z),
        .rot_vel_y   (rot_vel_y)
    );

endmodule

// ----- sim/scpfc_checker.sv -----
// ----------------------------------------------------------------------------
// scpfc_checker
// Watches the sample, command and register channels of the sliding-contact
// controller, predicts each velocity command and compares it field by field.
// ----------------------------------------------------------------------------
module scpfc_checker
    import scpfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [47:0]        sim_time,
    input  logic signed [17:0] axis_x,
    input  logic signed [31:0] normal_force,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] lin_vel_x,
    input  logic signed [31:0] lin_vel_z,
    input  logic signed [31:0] rot_vel_y,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        longint vx;
        longint vz;
        longint ry;
    } command_t;

    command_t cmd_q[$];

    // predictor copy of registers and loop state
    longint p_angle, p_speed, p_force, p_kp, p_ki, p_kw;
    longint hist_time, integ;
    bit     hist_seen;

    function automatic longint asr_f(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint sat_f(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rmul_f(longint a, longint b, int k);
        return (a * b + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint root_f(longint v);
        longint res;
        longint bitv;
        res  = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    // contact angle by CORDIC vectoring, Q30
    function automatic longint cordic_angle_f(longint c30, longint s30);
        longint x, y, z, dx, dy;
        x = c30;
        y = s30;
        z = 0;
        if (c30 < 0)
        begin
            x = s30;
            y = -c30;
            z = HALF_PI_Q30;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = asr_f(y, i);
            dy = asr_f(x, i);
            if (y > 0)
            begin
                x = x + dx; y = y - dy; z = z + longint'(atan_q30(i[4:0]));
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - longint'(atan_q30(i[4:0]));
            end
        end
        return z;
    endfunction

    // integral increment, magnitude capped at 2^33, rounding half away from zero
    function automatic longint integ_step(longint e, longint dt);
        bit          neg;
        logic [63:0] a, d, hi, lo, q;
        neg = (e < 0) != (dt < 0);
        a   = (e < 0) ? -e : e;
        d   = (dt < 0) ? -dt : dt;
        hi  = a * (d >> 24);
        lo  = a * (d & 64'hFF_FFFF);
        if (hi >= (64'd1 << 39))
            q = 64'd1 << 33;
        else
        begin
            q = ((hi << 24) + lo + (64'd1 << (TIME_FRAC_BITS - 1))) >> TIME_FRAC_BITS;
            if (q > (64'd1 << 33))
                q = 64'd1 << 33;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic command_t predict_command(logic [47:0] now, longint c, longint frc);
        command_t    r;
        longint      c30, s30, ang, w, fe, dt, pi_sum, m;
        logic [47:0] diff;
        if (c > 65536)
            c = 65536;
        if (c < -65536)
            c = -65536;
        c30 = c <<< (WQ - FRAC_BITS);
        s30 = root_f((64'sd1 <<< 60) - c30 * c30);
        ang = (cordic_angle_f(c30, s30) + (64'sd1 <<< (WQ - FRAC_BITS - 1)))
              >>> (WQ - FRAC_BITS);
        w   = sat_f(rmul_f(p_kw, ang - p_angle, FRAC_BITS));
        if (!hist_seen)
        begin
            hist_time = now;
            hist_seen = 1;
        end
        diff      = now - hist_time[47:0];
        dt        = longint'($signed(diff));
        hist_time = now;
        fe     = sat_f(-p_force - frc);
        integ  = sat_f(integ + integ_step(fe, dt));
        pi_sum = sat_f(rmul_f(p_kp, fe, FRAC_BITS) + rmul_f(p_ki, integ, FRAC_BITS));
        m      = rmul_f(w, LEVER_Q30, WQ);
        r.vx   = sat_f(-p_speed + rmul_f(m, s30, WQ));
        r.vz   = sat_f(pi_sum - rmul_f(m, c, FRAC_BITS));
        r.ry   = w;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    assign pending = cmd_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        command_t e;
        if (!rst_n)
        begin
            p_angle    = 65536;
            p_speed    = 328;
            p_force    = 655360;
            p_kp       = 6554;
            p_ki       = 3277;
            p_kw       = 3277;
            hist_time  = 0;
            hist_seen  = 0;
            integ      = 0;
            fail_count = 0;
            cmd_q.delete();
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TARGET_ANGLE: p_angle = cfg_data[17:0];
                    REG_TARGET_SPEED: p_speed = $signed(cfg_data);
                    REG_TARGET_FORCE: p_force = $signed(cfg_data);
                    REG_FORCE_P_GAIN: p_kp    = $signed(cfg_data);
                    REG_FORCE_I_GAIN: p_ki    = $signed(cfg_data);
                    REG_ANGLE_GAIN:   p_kw    = $signed(cfg_data);
                    default: ;
                endcase
            end
            // accepted samples
            if (in_valid && in_ready)
                cmd_q.push_back(predict_command(sim_time, axis_x, normal_force));
            // accepted commands
            if (out_valid && out_ready)
            begin
                if (cmd_q.size() == 0)
                    report_mismatch("command with no sample outstanding", lin_vel_x, 0);
                else
                begin
                    e = cmd_q.pop_front();
                    if (lin_vel_x != e.vx)
                        report_mismatch("lin_vel_x", lin_vel_x, e.vx);
                    if (lin_vel_z != e.vz)
                        report_mismatch("lin_vel_z", lin_vel_z, e.vz);
                    if (rot_vel_y != e.ry)
                        report_mismatch("rot_vel_y", rot_vel_y, e.ry);
                end
            end
        end
    end

endmodule

// ----- sim/sliding_contact_pi_force_control_core_tb.sv -----
// ----------------------------------------------------------------------------
// sliding_contact_pi_force_control_core_tb
// Drives samples and register writes into the controller under several idle
// and stall patterns; the checker predicts and compares every command.
// ----------------------------------------------------------------------------
module sliding_contact_pi_force_control_core_tb
    import scpfc_pkg::*;
();

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [47:0]        sim_time;
    logic signed [17:0] axis_x;
    logic signed [31:0] normal_force;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] lin_vel_x;
    logic signed [31:0] lin_vel_z;
    logic signed [31:0] rot_vel_y;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 pending;

    int          send_idle_pct;
    int          stall_pct;
    bit          hold_off;
    int          quiet_cycles;
    logic [47:0] stamp;

    localparam int QUIET_LIMIT = 20000;

    sliding_contact_pi_force_control_core dut (.*);

    scpfc_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver: random stall, or a long hold-off
    always @(posedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one write, then valid drops so writes never overlap
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // valid stays up between back-to-back items; the caller drops it at the end
    task automatic send_sample(logic [47:0] t, logic signed [17:0] c, logic signed [31:0] f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid     <= 1;
        sim_time     <= t;
        axis_x       <= c;
        normal_force <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [17:0] rand_axis();
        case ($urandom_range(9))
            0: return 18'sh1FFFF;
            1: return -18'sh20000;
            2: return $urandom;
            default: return $urandom_range(131072) - 65536;
        endcase
    endfunction

    // random samples: mostly steady time steps, some jumps and reversals
    task automatic random_run(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(19))
                0:       stamp = 48'({$urandom, $urandom});
                1:       stamp = stamp - $urandom_range(5000);
                default: stamp = stamp + $urandom_range(2000);
            endcase
            send_sample(stamp, rand_axis(),
                        ($urandom_range(3) == 0) ? rand_word() : $urandom_range(2000000) - 1000000);
        end
    endtask

    task automatic set_gains(bit wide);
        write_reg(REG_TARGET_ANGLE, wide ? $urandom : $urandom_range(205887));
        write_reg(REG_TARGET_SPEED, wide ? rand_word() : $urandom_range(2000));
        write_reg(REG_TARGET_FORCE, wide ? rand_word() : $urandom_range(1000000));
        write_reg(REG_FORCE_P_GAIN, wide ? rand_word() : $urandom_range(70000));
        write_reg(REG_FORCE_I_GAIN, wide ? rand_word() : $urandom_range(70000));
        write_reg(REG_ANGLE_GAIN,   wide ? rand_word() : $urandom_range(70000));
    endtask

    initial
    begin
        rst_n         = 0;
        in_valid      = 0;
        sim_time      = 0;
        axis_x        = 0;
        normal_force  = 0;
        cfg_valid     = 0;
        cfg_index     = REG_TARGET_ANGLE;
        cfg_data      = 0;
        out_ready     = 0;
        hold_off      = 0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        stamp         = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: first sample, axis extremes and clamping, force extremes
        send_sample(48'd1000, 18'sd0, 32'sd0);
        send_sample(48'd2000, 18'sd65536, -32'sd655360);
        send_sample(48'd3000, -18'sd65536, 32'sd100000);
        send_sample(48'd4000, 18'sh1FFFF, 32'sh7FFF_FFFF);
        send_sample(48'd5000, -18'sh20000, -32'sh8000_0000);
        send_sample(48'd4000, 18'sd32768, 32'sh7FFF_FFFF);
        send_sample(48'd0, -18'sd1, -32'sh8000_0000);
        send_sample(48'hFFFF_FFFF_FFFF, 18'sd1, 32'sd12345);
        send_sample(48'h7FFF_FFFF_FFFF, 18'sd65535, -32'sh8000_0000);
        send_sample(48'h8000_0000_0000, -18'sd65535, 32'sh7FFF_FFFF);
        send_sample(48'h0, 18'sd45000, 32'sd0);
        drain();

        // unknown index is ignored; register extremes
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0);
        write_reg(REG_TARGET_ANGLE, 32'd205887);
        write_reg(REG_TARGET_SPEED, 32'h8000_0000);
        write_reg(REG_TARGET_FORCE, 32'h7FFF_FFFF);
        write_reg(REG_FORCE_P_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_FORCE_I_GAIN, 32'h8000_0000);
        write_reg(REG_ANGLE_GAIN, 32'h7FFF_FFFF);
        send_sample(48'd10, 18'sd0, 32'sd0);
        send_sample(48'hFFFF_FFFF, -18'sd65536, -32'sh8000_0000);
        send_sample(48'd20, 18'sd65536, 32'sh7FFF_FFFF);
        drain();
        write_reg(REG_TARGET_ANGLE, 32'h3FFFF);
        write_reg(REG_TARGET_SPEED, 32'h7FFF_FFFF);
        write_reg(REG_TARGET_FORCE, 32'h8000_0000);
        write_reg(REG_FORCE_P_GAIN, 32'h8000_0000);
        write_reg(REG_FORCE_I_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_ANGLE_GAIN, 32'h8000_0000);
        send_sample(48'd30, 18'sd100, 32'sd0);
        send_sample(48'd0, -18'sd100, 32'sd5);
        drain();

        // random phases under differing idle patterns
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 77; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 77; end
                3: begin send_idle_pct = 33; stall_pct = 33; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            set_gains(ph == 3);
            random_run(230);
            drain();
        end

        // receiver holds off while samples keep coming
        send_idle_pct = 0;
        stall_pct     = 0;
        fork
            begin
                hold_off = 1;
                repeat (1500) @(posedge clk);
                hold_off = 0;
            end
            begin
                random_run(20);
                in_valid <= 0;
            end
        join
        drain();

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sliding_contact_pi_force_control_core.f -----
sv/scpfc_pkg.sv
sv/scpfc_queue.sv
sv/scpfc_front.sv
sv/scpfc_back.sv
sv/sliding_contact_pi_force_control_core.sv
sim/scpfc_checker.sv
sim/sliding_contact_pi_force_control_core_tb.sv
